### rtl/kavs_pkg.sv
// kavs_pkg: shared types and codes for the kth allowed value selector
// item kinds, status codes, sequencer and search-unit state types
// no dependencies
package kavs_pkg;

	localparam int DATA_W   = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;

	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PICK   = 2'd2;

	// register index of universe_size, taken from paddr[2]
	localparam logic REG_UNIVERSE = 1'b0;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK         = 3'd0,
		STS_RANK_RANGE = 3'd1,
		STS_OUTSIDE    = 3'd2,
		STS_FULL       = 3'd3,
		STS_DUP        = 3'd4
	} kavs_status_t;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_INS_FIND,
		SEQ_INS_RD,
		SEQ_INS_CHK,
		SEQ_SHIFT_RD,
		SEQ_SHIFT_WR,
		SEQ_INS_WR,
		SEQ_LOW_N,
		SEQ_RANK,
		SEQ_FINAL,
		SEQ_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		SRCH_IDLE,
		SRCH_ISSUE,
		SRCH_CMP
	} srch_phase_t;

	typedef struct packed {
		logic go;
		logic rank_mode;
	} srch_ctl_t;

endpackage

### rtl/kth_allowed_value_selector_top.sv
// kth_allowed_value_selector_top: sequencer, registers and table of the selector
// depends on kavs_pkg, kavs_mem and kavs_search
//
// channel   signals                                   handshake
// -------   ---------------------------------------   ---------------------------
// item in   start, kind, operand                      taken when start && !busy
// result    done, picked_value, allowed_count, status one-cycle strobe on done
// config    psel penable pwrite paddr pwdata prdata   apb, pready tied high
//
// a search over k entries loads its bounds, then probes through the registered table read port,
// each probe presenting an address and then comparing the returned entry, until the range is empty.
// a pick runs one search, two when the rank is in range; an unknown kind runs one search;
// an insert runs two searches (one when the value is outside the universe), a read and a check
// for duplicates, the write, and a read and a write per shifted entry; a clear has no work
// before its strobe. busy stays high from the accepting edge until the one-cycle strobe ends.
// the table needs no clearing pass after reset; the receiver cannot stall results.
module kth_allowed_value_selector_top #(
	parameter int MAX_EXCLUDED = 1024,
	parameter int VALUE_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [kavs_pkg::KIND_W-1:0]   kind,
	input  logic [kavs_pkg::DATA_W-1:0]   operand,
	output logic                          done,
	output logic [kavs_pkg::DATA_W-1:0]   picked_value,
	output logic [kavs_pkg::DATA_W-1:0]   allowed_count,
	output logic [kavs_pkg::STATUS_W-1:0] status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import kavs_pkg::*;

	localparam int CNT_W = $clog2(MAX_EXCLUDED + 1);
	localparam int IDX_W = (MAX_EXCLUDED > 1) ? $clog2(MAX_EXCLUDED) : 1;

	seq_state_t        state_q, state_d;
	logic [31:0]       universe_q;
	logic [DATA_W-1:0] n_w;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  i_dec;
	logic [CNT_W-1:0]  m_q;
	logic [DATA_W-1:0] op_q;
	logic [DATA_W-1:0] picked_q;
	logic [DATA_W-1:0] allowed_q;
	kavs_status_t      status_q;
	logic [DATA_W-1:0] allowed_now;
	logic              table_full;
	logic              is_dup;

	srch_ctl_t         s_ctl;
	logic [DATA_W-1:0] s_key;
	logic [CNT_W-1:0]  s_hi;
	logic [IDX_W-1:0]  s_raddr;
	logic              s_done;
	logic [CNT_W-1:0]  s_result;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [VALUE_BITS-1:0] mem_wdata;
	logic [IDX_W-1:0]      mem_raddr;
	logic [VALUE_BITS-1:0] mem_rdata;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_UNIVERSE) ? universe_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			universe_q <= 32'd1;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_UNIVERSE)) begin
			universe_q <= pwdata;
		end
	end

	assign n_w         = DATA_W'(universe_q[VALUE_BITS-1:0]);
	assign allowed_now = n_w - DATA_W'(s_result);
	assign i_dec       = i_q - CNT_W'(1);
	assign table_full  = count_q >= CNT_W'(MAX_EXCLUDED);
	assign is_dup      = DATA_W'(mem_rdata) == op_q;

	assign busy          = state_q != SEQ_IDLE;
	assign done          = state_q == SEQ_DONE;
	assign picked_value  = picked_q;
	assign allowed_count = allowed_q;
	assign status        = status_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					case (kind)
						KIND_CLEAR:  state_d = SEQ_DONE;
						KIND_INSERT: state_d = (operand >= n_w) ? SEQ_FINAL : SEQ_INS_FIND;
						KIND_PICK:   state_d = SEQ_LOW_N;
						default:     state_d = SEQ_FINAL;
					endcase
				end
			end
			SEQ_INS_FIND: begin
				if (s_done) begin
					if (s_result < count_q) begin
						state_d = SEQ_INS_RD;
					end else if (table_full) begin
						state_d = SEQ_FINAL;
					end else begin
						state_d = SEQ_INS_WR;
					end
				end
			end
			SEQ_INS_RD: state_d = SEQ_INS_CHK;
			SEQ_INS_CHK: begin
				state_d = (is_dup || table_full) ? SEQ_FINAL : SEQ_SHIFT_RD;
			end
			SEQ_SHIFT_RD: state_d = SEQ_SHIFT_WR;
			SEQ_SHIFT_WR: state_d = (i_dec > pos_q) ? SEQ_SHIFT_RD : SEQ_INS_WR;
			SEQ_INS_WR:   state_d = SEQ_FINAL;
			SEQ_LOW_N: begin
				if (s_done) begin
					state_d = (op_q >= allowed_now) ? SEQ_DONE : SEQ_RANK;
				end
			end
			SEQ_RANK: begin
				if (s_done) begin
					state_d = SEQ_DONE;
				end
			end
			SEQ_FINAL: begin
				if (s_done) begin
					state_d = SEQ_DONE;
				end
			end
			SEQ_DONE: state_d = SEQ_IDLE;
			default:  state_d = SEQ_IDLE;
		endcase
	end

	// outputs to search unit and table
	always_comb begin
		s_ctl.go        = 1'b0;
		s_ctl.rank_mode = 1'b0;
		s_key           = n_w;
		s_hi            = count_q;
		mem_we          = 1'b0;
		mem_waddr       = pos_q[IDX_W-1:0];
		mem_wdata       = op_q[VALUE_BITS-1:0];
		mem_raddr       = s_raddr;
		unique case (state_q)
			SEQ_INS_FIND: begin
				s_ctl.go = 1'b1;
				s_key    = op_q;
			end
			SEQ_LOW_N, SEQ_FINAL: begin
				s_ctl.go = 1'b1;
			end
			SEQ_RANK: begin
				s_ctl.go        = 1'b1;
				s_ctl.rank_mode = 1'b1;
				s_key           = op_q;
				s_hi            = m_q;
			end
			SEQ_INS_RD: begin
				mem_raddr = pos_q[IDX_W-1:0];
			end
			SEQ_SHIFT_RD: begin
				mem_raddr = i_dec[IDX_W-1:0];
			end
			SEQ_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = i_q[IDX_W-1:0];
				mem_wdata = mem_rdata;
			end
			SEQ_INS_WR: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SEQ_IDLE && start && kind == KIND_CLEAR) begin
				count_q <= '0;
			end else if (state_q == SEQ_INS_WR) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// item datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					op_q      <= operand;
					picked_q  <= '0;
					allowed_q <= n_w;
					status_q  <= STS_OK;
					if (kind == KIND_INSERT && operand >= n_w) begin
						status_q <= STS_OUTSIDE;
					end
				end
			end
			SEQ_INS_FIND: begin
				if (s_done) begin
					pos_q <= s_result;
					i_q   <= count_q;
					if (!(s_result < count_q) && table_full) begin
						status_q <= STS_FULL;
					end
				end
			end
			SEQ_INS_CHK: begin
				if (is_dup) begin
					status_q <= STS_DUP;
				end else if (table_full) begin
					status_q <= STS_FULL;
				end
			end
			SEQ_SHIFT_WR: begin
				i_q <= i_dec;
			end
			SEQ_LOW_N: begin
				if (s_done) begin
					m_q       <= s_result;
					allowed_q <= allowed_now;
					if (op_q >= allowed_now) begin
						status_q <= STS_RANK_RANGE;
					end
				end
			end
			SEQ_RANK: begin
				if (s_done) begin
					picked_q <= op_q + DATA_W'(s_result);
				end
			end
			SEQ_FINAL: begin
				if (s_done) begin
					allowed_q <= allowed_now;
				end
			end
			default: begin
			end
		endcase
	end

	kavs_search #(
		.CNT_W      (CNT_W),
		.IDX_W      (IDX_W),
		.VALUE_BITS (VALUE_BITS)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (s_ctl),
		.key     (s_key),
		.hi_init (s_hi),
		.rdata   (mem_rdata),
		.raddr   (s_raddr),
		.done    (s_done),
		.result  (s_result)
	);

	kavs_mem #(
		.DEPTH (MAX_EXCLUDED),
		.AW    (IDX_W),
		.DW    (VALUE_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

### rtl/kavs_mem.sv
// kavs_mem: table of excluded values, one write port and one registered read port
// depends on nothing but its parameters
module kavs_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/kavs_search.sv
// kavs_search: shared binary search unit over the excluded-value table
// each probe presents an address, then compares the registered data; uses kavs_pkg
module kavs_search #(
	parameter int CNT_W      = 11,
	parameter int IDX_W      = 10,
	parameter int VALUE_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kavs_pkg::srch_ctl_t      ctl,
	input  logic [kavs_pkg::DATA_W-1:0] key,
	input  logic [CNT_W-1:0]         hi_init,
	input  logic [VALUE_BITS-1:0]    rdata,
	output logic [IDX_W-1:0]         raddr,
	output logic                     done,
	output logic [CNT_W-1:0]         result
);
	import kavs_pkg::*;

	srch_phase_t      phase_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] mid;
	logic [DATA_W-1:0] entry;
	logic [DATA_W-1:0] mid_w;
	logic             go_right;

	assign sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid   = sum[CNT_W:1];
	assign raddr = mid[IDX_W-1:0];
	assign entry = DATA_W'(rdata);
	assign mid_w = DATA_W'(mid);

	// lower mode: entry < key; rank mode: not (entry - index > key)
	always_comb begin
		if (ctl.rank_mode) begin
			go_right = !((entry - mid_w) > key);
		end else begin
			go_right = entry < key;
		end
	end

	assign done   = (phase_q == SRCH_ISSUE) && !(lo_q < hi_q);
	assign result = lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= SRCH_IDLE;
		end else begin
			unique case (phase_q)
				SRCH_IDLE: begin
					if (ctl.go) begin
						phase_q <= SRCH_ISSUE;
					end
				end
				SRCH_ISSUE: begin
					phase_q <= (lo_q < hi_q) ? SRCH_CMP : SRCH_IDLE;
				end
				SRCH_CMP: begin
					phase_q <= SRCH_ISSUE;
				end
				default: begin
					phase_q <= SRCH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == SRCH_IDLE) begin
			lo_q <= '0;
			hi_q <= hi_init;
		end else if (phase_q == SRCH_CMP) begin
			if (go_right) begin
				lo_q <= mid + CNT_W'(1);
			end else begin
				hi_q <= mid;
			end
		end
	end

endmodule

### tb/sv/kth_allowed_value_selector_top_tb.sv
`timescale 1ns / 1ps
// kth_allowed_value_selector_top_tb: self-checking bench for the kth allowed value selector
// drives items and apb register writes, predicts each result from a table model and checks it
// depends on kavs_pkg and kth_allowed_value_selector_top
module kth_allowed_value_selector_top_tb;
	import kavs_pkg::*;

	localparam int TABLE_DEPTH   = 1024;
	localparam int CYCLE_LIMIT   = 10000000;
	localparam int SETTLE_CYCLES = 100;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
	localparam logic [2:0] UNIVERSE_ADDR = {REG_UNIVERSE, 2'b00};

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] operand;
		logic              drain_first;
	} sel_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] picked;
		logic [DATA_W-1:0] allowed;
		kavs_status_t      sts;
	} sel_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [KIND_W-1:0]   kind = '0;
	logic [DATA_W-1:0]   operand = '0;
	logic                busy;
	logic                done;
	logic [DATA_W-1:0]   picked_value;
	logic [DATA_W-1:0]   allowed_count;
	logic [STATUS_W-1:0] status;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [2:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	// table model
	logic [DATA_W-1:0] excl_tbl [TABLE_DEPTH];
	int unsigned       excl_cnt = 0;
	logic [DATA_W-1:0] universe_n = 32'd1;

	sel_item_t   pending_items [$];
	sel_result_t results_due [$];
	int          items_sent = 0;
	int          items_taken = 0;
	int          sender_idle_pct = 7;
	int          mismatches = 0;
	int          cycle_count = 0;

	kth_allowed_value_selector_top dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .kind(kind), .operand(operand),
		.done(done), .picked_value(picked_value), .allowed_count(allowed_count),
		.status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h (cycle %0d)", field, got, want, cycle_count);
		mismatches++;
	endtask

	// first table index whose entry is >= v
	function automatic int unsigned first_at_or_above(input logic [DATA_W-1:0] v);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = excl_cnt;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (excl_tbl[mid] < v)
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	task automatic predict_selection(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] op);
		sel_result_t       r;
		int unsigned       pos;
		int unsigned       lo;
		int unsigned       hi;
		int unsigned       mid;
		logic [DATA_W-1:0] avail;
		r.picked = '0;
		r.sts = STS_OK;
		case (k)
			KIND_CLEAR: begin
				excl_cnt = 0;
			end
			KIND_INSERT: begin
				if (op >= universe_n) begin
					r.sts = STS_OUTSIDE;
				end else begin
					pos = first_at_or_above(op);
					if (pos < excl_cnt && excl_tbl[pos] == op) begin
						r.sts = STS_DUP;
					end else if (excl_cnt >= TABLE_DEPTH) begin
						r.sts = STS_FULL;
					end else begin
						for (int unsigned i = excl_cnt; i > pos; i--)
							excl_tbl[i] = excl_tbl[i-1];
						excl_tbl[pos] = op;
						excl_cnt++;
					end
				end
			end
			KIND_PICK: begin
				hi = first_at_or_above(universe_n);
				avail = universe_n - DATA_W'(hi);
				if (op >= avail) begin
					r.sts = STS_RANK_RANGE;
				end else begin
					// first entry whose gap count exceeds the rank
					lo = 0;
					while (lo < hi) begin
						mid = lo + (hi - lo) / 2;
						if (excl_tbl[mid] - DATA_W'(mid) > op)
							hi = mid;
						else
							lo = mid + 1;
					end
					r.picked = op + DATA_W'(lo);
				end
			end
			default: ;
		endcase
		r.allowed = universe_n - DATA_W'(first_at_or_above(universe_n));
		results_due = {results_due, r};
	endtask

	task automatic queue_item(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] op,
			input logic drain_first = 1'b0);
		sel_item_t it;
		it.kind = k;
		it.operand = op;
		it.drain_first = drain_first;
		pending_items = {pending_items, it};
		items_sent++;
	endtask

	task automatic wait_drained();
		while (!(items_taken == items_sent && results_due.size() == 0))
			@(posedge clk);
	endtask

	// register write plus readback, only called with the block idle
	task automatic set_universe(input logic [31:0] value);
		wait_drained();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= UNIVERSE_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		universe_n = value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== value)
			report_mismatch("universe_size readback", prdata, value);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] insert_value();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (universe_n == 0 || roll >= 90)
			return $urandom();
		if (roll >= 80)
			return universe_n + $urandom_range(3, 0);
		return $urandom_range(universe_n - 1, 0);
	endfunction

	function automatic logic [DATA_W-1:0] pick_rank();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (universe_n == 0 || roll >= 95)
			return $urandom();
		// ranks near the top land on both sides of the allowed count
		if (roll >= 75)
			return universe_n - 1 - $urandom_range(universe_n > 8 ? 8 : universe_n - 1, 0);
		return $urandom_range(universe_n - 1, 0);
	endfunction

	task automatic random_mix(input int count);
		int unsigned roll;
		logic        hold;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99, 0);
			hold = ($urandom_range(49, 0) == 0);
			if (roll < 4)
				queue_item(KIND_CLEAR, $urandom(), hold);
			else if (roll < 50)
				queue_item(KIND_INSERT, insert_value(), hold);
			else if (roll < 96)
				queue_item(KIND_PICK, pick_rank(), hold);
			else
				queue_item(KIND_NONE, $urandom(), hold);
		end
	endtask

	// sender: presents the next queued item, holds it until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			kind <= '0;
			operand <= '0;
		end else begin
			if (start && !busy) begin
				predict_selection(kind, operand);
				items_taken++;
			end
			if (!start || !busy) begin
				if (pending_items.size() != 0
						&& !(pending_items[0].drain_first && results_due.size() != 0)
						&& $urandom_range(99, 0) >= sender_idle_pct) begin
					start <= 1'b1;
					kind <= pending_items[0].kind;
					operand <= pending_items[0].operand;
					void'(pending_items.pop_front());
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		sel_result_t want;
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				report_mismatch("result with nothing expected", picked_value, 32'd0);
			end else begin
				want = results_due.pop_front();
				if (picked_value !== want.picked)
					report_mismatch("picked_value", picked_value, want.picked);
				if (allowed_count !== want.allowed)
					report_mismatch("allowed_count", allowed_count, want.allowed);
				if (status !== want.sts)
					report_mismatch("status", 32'(status), 32'(want.sts));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL kth_allowed_value_selector_top");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset universe of one value
		sender_idle_pct = 7;
		queue_item(KIND_PICK, 32'd0);
		queue_item(KIND_INSERT, 32'd0);
		queue_item(KIND_PICK, 32'd0);
		queue_item(KIND_INSERT, 32'd0);
		queue_item(KIND_INSERT, 32'd1);
		queue_item(KIND_INSERT, 32'hFFFF_FFFF);
		queue_item(KIND_NONE, 32'hFFFF_FFFF);
		queue_item(KIND_CLEAR, 32'hFFFF_FFFF);
		queue_item(KIND_PICK, 32'd0);

		// empty universe
		set_universe(32'd0);
		queue_item(KIND_INSERT, 32'd0);
		queue_item(KIND_PICK, 32'd0);
		queue_item(KIND_PICK, 32'hFFFF_FFFF);

		// widest universe, top rank on both sides of the allowed count
		set_universe(32'hFFFF_FFFF);
		queue_item(KIND_INSERT, 32'hFFFF_FFFE);
		queue_item(KIND_INSERT, 32'd0);
		queue_item(KIND_PICK, 32'hFFFF_FFFC);
		queue_item(KIND_PICK, 32'hFFFF_FFFD);
		queue_item(KIND_INSERT, 32'hFFFF_FFFF);
		queue_item(KIND_PICK, 32'd0);
		queue_item(KIND_INSERT, 32'hFFFF_FFFE);

		// values left above a shrunk universe must not count
		set_universe(32'd20);
		queue_item(KIND_CLEAR, 32'd0);
		queue_item(KIND_INSERT, 32'd15);
		queue_item(KIND_INSERT, 32'd5);
		queue_item(KIND_INSERT, 32'd10);
		set_universe(32'd12);
		queue_item(KIND_PICK, 32'd9);
		queue_item(KIND_PICK, 32'd10);
		queue_item(KIND_INSERT, 32'd15);

		set_universe(32'd64);
		random_mix(40);
		set_universe($urandom());
		random_mix(20);

		sender_idle_pct = 51;
		set_universe(32'hFFFF_FFFF);
		random_mix(40);
		set_universe($urandom_range(1000, 2));
		random_mix(30);

		// fill the table to capacity, appending in order to keep shifts short
		sender_idle_pct = 0;
		set_universe(32'd3000);
		queue_item(KIND_CLEAR, 32'd0);
		for (int i = 0; i < TABLE_DEPTH - 4; i++) begin
			queue_item(KIND_INSERT, 32'(10 + 2 * i) + $urandom_range(1, 0));
			if (i % 64 == 63)
				queue_item(KIND_PICK, $urandom_range(2999, 0));
		end
		// low values shift the whole table
		queue_item(KIND_INSERT, 32'd9);
		queue_item(KIND_INSERT, 32'd0);
		queue_item(KIND_INSERT, 32'd5);
		queue_item(KIND_INSERT, 32'd3);
		queue_item(KIND_INSERT, 32'd9);
		queue_item(KIND_INSERT, 32'd2999);
		queue_item(KIND_INSERT, 32'd3000);
		queue_item(KIND_PICK, 32'd0);
		queue_item(KIND_PICK, 32'd1975);
		queue_item(KIND_PICK, 32'd1976);
		set_universe(32'd500);
		for (int i = 0; i < 8; i++)
			queue_item(KIND_PICK, pick_rank());
		queue_item(KIND_INSERT, 32'd499);

		set_universe($urandom_range(40, 1));
		queue_item(KIND_CLEAR, 32'd0);
		random_mix(20);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("PASS kth_allowed_value_selector_top");
		end else begin
			$display("FAIL kth_allowed_value_selector_top");
		end
		$finish;
	end

endmodule
